>>> rtl/core/alt_pkg.sv
// shared types and constants for the shift-delete array list
// no dependencies; used by alt_cell and array_list_shift_delete
package alt_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DONE = 2'd2
  } fsm_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic append_en;
    logic remove_en;
    logic read_en;
    logic tap_load;
  } cell_ctl_t;

endpackage

>>> rtl/core/alt_cell.sv
// one entry cell of the list: holds a word, shifts down from its upper neighbor
// depends on alt_pkg (cell_ctl_t)
module alt_cell #(
  parameter int WORD_BITS = alt_pkg::WORD_BITS_DEF,
  parameter int CMP_W     = 7,
  parameter int IDX       = 0
) (
  input  logic                  clk,
  input  alt_pkg::cell_ctl_t    ctl,
  input  logic [CMP_W-1:0]      pos,
  input  logic [CMP_W-1:0]      count,
  input  logic [CMP_W-1:0]      read_idx,
  input  logic [WORD_BITS-1:0]  wr_word,
  input  logic [WORD_BITS-1:0]  upper_word,
  output logic [WORD_BITS-1:0]  word,
  output logic [WORD_BITS-1:0]  tap
);

  localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] MY_NEXT = CMP_W'(IDX + 1);

  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [WORD_BITS-1:0] tap_r, tap_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.append_en && (count == MY_IDX)) begin
      word_nxt = wr_word;
    end else if (ctl.remove_en && (MY_IDX >= pos) && (MY_NEXT < count)) begin
      word_nxt = upper_word;
    end
  end

  always_comb begin
    tap_nxt = tap_r;
    if (ctl.tap_load) begin
      tap_nxt = (ctl.read_en && (read_idx == MY_IDX)) ? word_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    tap_r  <= tap_nxt;
  end

  assign word = word_r;
  assign tap  = tap_r;

endmodule

>>> rtl/core/array_list_shift_delete.sv
// top level of the shift-delete array list: sequencer, cell chain, result register
// depends on alt_pkg and alt_cell
//
// Fixed-capacity ordered list of DEPTH words held in a chain of entry cells.
// Each input item is one operation (append, get by index, remove by index,
// pop last) and gives exactly one result item with a status, the word read,
// the position an append used and the entry count after the operation.
// Each item passes through three steps: accept, execute (all cells update in
// parallel, a remove shifts every later cell down by one in that same step,
// and the selected cell latches its word into its read tap), then an OR over
// the taps that loads the output register. The next item is taken only once
// the sequencer is back in idle, so a new item is not accepted before the last
// one is through; a held result stalls the sequencer in its last step but
// never loses data. The count resets to zero; entry words have no reset and
// are only ever read below the count.
module array_list_shift_delete #(
  parameter int DEPTH     = alt_pkg::DEPTH_DEF,
  parameter int WORD_BITS = alt_pkg::WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [5:0]  in_position,
  input  logic [31:0] in_item_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [5:0]  out_stored_at,
  output logic [6:0]  out_entry_count
);

  // count and compare widths
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int EXT_W  = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // state and registers
  alt_pkg::fsm_t    state_r, state_nxt;
  alt_pkg::op_t     op_r;
  logic [5:0]       pos_r;
  logic [31:0]      val_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  // result held between execute and done
  alt_pkg::status_t res_status_r, res_status_nxt;
  logic [CMP_W-1:0] res_at_r, res_at_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  alt_pkg::status_t out_status_r;
  logic [31:0]      out_read_r;
  logic [5:0]       out_at_r;
  logic [6:0]       out_count_r;

  logic in_acc, out_load;
  alt_pkg::cell_ctl_t ctl;
  logic [CMP_W-1:0] pos_w, cnt_w, read_idx;
  logic [EXT_W-1:0] val_ext, rd_ext;
  logic [WORD_BITS-1:0] wr_word, rd_or;
  logic [WORD_BITS-1:0] words [DEPTH];
  logic [WORD_BITS-1:0] taps  [DEPTH];
  logic [CMP_W-1:0] cnt_out_ext;

  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == alt_pkg::S_DONE) && (!out_valid_r || out_ready);

  assign pos_w   = CMP_W'(pos_r);
  assign cnt_w   = CMP_W'(count_r);
  assign val_ext = EXT_W'(val_r);
  assign wr_word = val_ext[WORD_BITS-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alt_pkg::S_IDLE: if (in_acc)   state_nxt = alt_pkg::S_EXEC;
      alt_pkg::S_EXEC:               state_nxt = alt_pkg::S_DONE;
      alt_pkg::S_DONE: if (out_load) state_nxt = alt_pkg::S_IDLE;
      default:                       state_nxt = alt_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs: checks, cell control and count update in the execute step
  always_comb begin
    ctl            = '0;
    read_idx       = pos_w;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_at_nxt     = res_at_r;
    in_ready       = 1'b0;
    case (state_r)
      alt_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      alt_pkg::S_EXEC: begin
        ctl.tap_load   = 1'b1;
        res_status_nxt = alt_pkg::ST_OK;
        res_at_nxt     = '0;
        case (op_r)
          alt_pkg::OP_APPEND: begin
            if (count_r == FULL_CNT) begin
              res_status_nxt = alt_pkg::ST_FULL;
            end else begin
              ctl.append_en = 1'b1;
              res_at_nxt    = cnt_w;
              count_nxt     = count_r + 1'b1;
            end
          end
          alt_pkg::OP_GET: begin
            if (pos_w >= cnt_w) begin
              res_status_nxt = alt_pkg::ST_RANGE;
            end else begin
              ctl.read_en = 1'b1;
            end
          end
          alt_pkg::OP_REMOVE: begin
            if (pos_w >= cnt_w) begin
              res_status_nxt = alt_pkg::ST_RANGE;
            end else begin
              ctl.remove_en = 1'b1;
              count_nxt     = count_r - 1'b1;
            end
          end
          alt_pkg::OP_POP: begin
            if (count_r == '0) begin
              res_status_nxt = alt_pkg::ST_EMPTY;
            end else begin
              ctl.read_en = 1'b1;
              read_idx    = cnt_w - 1'b1;
              count_nxt   = count_r - 1'b1;
            end
          end
          default: res_status_nxt = alt_pkg::ST_OK;
        endcase
      end
      default: ;
    endcase
  end

  // chain of entry cells; each takes its upper neighbor's word on a remove
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] upper;
    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = words[g+1];
    end
    alt_cell #(
      .WORD_BITS (WORD_BITS),
      .CMP_W     (CMP_W),
      .IDX       (g)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos_w),
      .count      (cnt_w),
      .read_idx   (read_idx),
      .wr_word    (wr_word),
      .upper_word (upper),
      .word       (words[g]),
      .tap        (taps[g])
    );
  end

  // at most one tap is nonzero, so an OR picks the read word
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | taps[i];
    end
  end

  assign rd_ext      = EXT_W'(rd_or);
  assign cnt_out_ext = CMP_W'(count_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= alt_pkg::op_t'(in_operation);
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    res_status_r <= res_status_nxt;
    res_at_r     <= res_at_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_read_r   <= rd_ext[31:0];
      out_at_r     <= res_at_r[5:0];
      out_count_r  <= cnt_out_ext[6:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_r;
  assign out_stored_at   = out_at_r;
  assign out_entry_count = out_count_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == alt_pkg::S_DONE))
    else $error("result raised outside the done step");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alt_pkg::S_EXEC && op_r == alt_pkg::OP_APPEND && count_r != FULL_CNT)
      |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not grow the list");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alt_pkg::S_EXEC && res_status_nxt != alt_pkg::ST_OK) |=> $stable(count_r))
    else $error("failed operation changed the count");

  a_idle_only_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == alt_pkg::S_DONE && !out_load) |=> (state_r == alt_pkg::S_DONE && !in_ready))
    else $error("sequencer left done while the result was held");

endmodule
